// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL that carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/core/xeu_pkg.sv -----
// Shared types, constants and lookup functions of the entity unescaper
package xeu_pkg;

   // Default longest entity span, including the opening '&'
   localparam int unsigned SPAN_DEFAULT = 16;

   // Command queue between parser and expander
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QP_W        = $clog2(QUEUE_DEPTH);
   localparam int unsigned QC_W        = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned CODE_W   = 21;
   localparam int unsigned NAME_COUNT = 5;

   localparam logic [CODE_W-1:0] CODE_MAX = 21'h10FFFF;

   // Characters the parser looks for
   localparam logic [7:0] CH_AMP  = 8'h26;
   localparam logic [7:0] CH_SEMI = 8'h3B;
   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_X    = 8'h78;

   // UTF-8 marker bits
   localparam logic [7:0] UTF8_CONT  = 8'h80;
   localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
   localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
   localparam logic [7:0] UTF8_LEAD4 = 8'hF0;

   // Result kinds
   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_ERROR = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Commands from parser to expander
   typedef logic [1:0] op_type;
   localparam op_type OP_RAW   = 2'd0;  // one byte as is
   localparam op_type OP_CODE  = 2'd1;  // code point, sent as UTF-8
   localparam op_type OP_ERROR = 2'd2;  // malformed entity
   localparam op_type OP_END   = 2'd3;  // string end after discard

   typedef struct packed {
      op_type              op;
      logic [CODE_W-1:0]   code;
      logic                last;
   } cmd_type;

   // Length of a named entity body
   function automatic logic [2:0] name_len(input logic [2:0] k);
      logic [2:0] len;
      case (k)
         3'd0:    len = 3'd3;   // amp
         3'd1:    len = 3'd2;   // lt
         3'd2:    len = 3'd2;   // gt
         3'd3:    len = 3'd4;   // quot
         3'd4:    len = 3'd4;   // apos
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // Character at a position of a named entity body
   function automatic logic [7:0] name_chr(input logic [2:0] k, input logic [1:0] pos);
      logic [31:0] text;
      case (k)
         3'd0:    text = {8'h00, "pma"};
         3'd1:    text = {16'h0000, "tl"};
         3'd2:    text = {16'h0000, "tg"};
         3'd3:    text = "touq";
         3'd4:    text = "sopa";
         default: text = '0;
      endcase
      return text[pos*8 +: 8];
   endfunction

   // Character a named entity stands for
   function automatic logic [7:0] name_char(input logic [2:0] k);
      logic [7:0] ch;
      case (k)
         3'd0:    ch = 8'h26;
         3'd1:    ch = 8'h3C;
         3'd2:    ch = 8'h3E;
         3'd3:    ch = 8'h22;
         3'd4:    ch = 8'h27;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Allowed XML character values
   function automatic logic legal_xml(input logic [CODE_W-1:0] v);
      return (v == 21'd9) || (v == 21'd10) || (v == 21'd13) ||
             (v >= 21'h20 && v <= 21'hD7FF) ||
             (v >= 21'hE000 && v <= 21'hFFFD) ||
             (v >= 21'h10000 && v <= CODE_MAX);
   endfunction

endpackage

// ----- rtl/core/xeu_front.sv -----
// Parser: takes one byte per cycle while accept is high, tracks entity state and issues commands
module xeu_front import xeu_pkg::*; #(
   parameter int unsigned MAX_ENTITY_SPAN = SPAN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       in_last,
   output logic       cmd_push,
   output cmd_type    cmd_data
);

   localparam int unsigned BL_W = $clog2(MAX_ENTITY_SPAN);
   localparam logic [BL_W-1:0] SPAN_LIM = BL_W'(MAX_ENTITY_SPAN - 1);

   localparam logic [1:0] MODE_PLAIN   = 2'd0;
   localparam logic [1:0] MODE_ENTITY  = 2'd1;
   localparam logic [1:0] MODE_DISCARD = 2'd2;

   logic [1:0]            mode_ff, mode_in;
   logic [BL_W-1:0]       body_len_ff, body_len_in;
   logic [NAME_COUNT-1:0] cand_ff, cand_in;
   logic                  numeric_ff, numeric_in;
   logic                  hex_ff, hex_in;
   logic                  digit_ff, digit_in;
   logic                  bad_ff, bad_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic                  ovf_ff, ovf_in;

   logic [NAME_COUNT-1:0] cand_next;
   logic                  is_dec, is_lhex, is_uhex, digit_ok;
   logic [3:0]            digit_val;
   logic [CODE_W+3:0]     acc;
   logic                  acc_over;
   logic                  named_hit;
   logic [7:0]            named_ch;
   logic                  finish_ok;
   logic                  err;

   // Named entities still matching after this byte
   always_comb begin
      for (int k = 0; k < NAME_COUNT; k++) begin
         cand_next[k] = cand_ff[k] &&
                        (body_len_ff < BL_W'(name_len(3'(k)))) &&
                        (name_chr(3'(k), body_len_ff[1:0]) == in_byte);
      end
   end

   // Digit decode and value accumulation
   always_comb begin
      is_dec    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
      is_lhex   = (in_byte >= 8'h61) && (in_byte <= 8'h66);
      is_uhex   = (in_byte >= 8'h41) && (in_byte <= 8'h46);
      digit_ok  = is_dec || (hex_ff && (is_lhex || is_uhex));
      digit_val = is_dec ? in_byte[3:0] : in_byte[3:0] + 4'd9;
      if (hex_ff) begin
         acc = {code_ff, 4'b0000} + (CODE_W+4)'(digit_val);
      end else begin
         acc = {1'b0, code_ff, 3'b000} + {3'b000, code_ff, 1'b0} + (CODE_W+4)'(digit_val);
      end
      acc_over = acc > (CODE_W+4)'(CODE_MAX);
   end

   // Entity completion check on ';'
   always_comb begin
      named_hit = 1'b0;
      named_ch  = 8'h00;
      for (int k = 0; k < NAME_COUNT; k++) begin
         if (!named_hit && cand_ff[k] && (BL_W'(name_len(3'(k))) == body_len_ff)) begin
            named_hit = 1'b1;
            named_ch  = name_char(3'(k));
         end
      end
      if (body_len_ff == '0) begin
         finish_ok = 1'b0;
      end else if (numeric_ff) begin
         finish_ok = digit_ff && !bad_ff && !ovf_ff && legal_xml(code_ff);
      end else begin
         finish_ok = named_hit;
      end
   end

   // Parse state machine
   always_comb begin
      mode_in     = mode_ff;
      body_len_in = body_len_ff;
      cand_in     = cand_ff;
      numeric_in  = numeric_ff;
      hex_in      = hex_ff;
      digit_in    = digit_ff;
      bad_in      = bad_ff;
      code_in     = code_ff;
      ovf_in      = ovf_ff;
      cmd_push    = 1'b0;
      cmd_data.op   = OP_RAW;
      cmd_data.code = {{(CODE_W-8){1'b0}}, in_byte};
      cmd_data.last = in_last;
      err = 1'b0;
      if (accept) begin
         case (mode_ff)
            MODE_DISCARD: begin
               if (in_last) begin
                  cmd_push    = 1'b1;
                  cmd_data.op = OP_END;
               end
            end
            MODE_ENTITY: begin
               if (in_byte == CH_SEMI) begin
                  if (finish_ok) begin
                     cmd_push = 1'b1;
                     if (numeric_ff) begin
                        cmd_data.op   = OP_CODE;
                        cmd_data.code = code_ff;
                     end else begin
                        cmd_data.code = {{(CODE_W-8){1'b0}}, named_ch};
                     end
                     mode_in = MODE_PLAIN;
                  end else begin
                     err = 1'b1;
                  end
               end else if (body_len_ff >= SPAN_LIM || in_last) begin
                  err = 1'b1;
               end else begin
                  cand_in = cand_next;
                  if (body_len_ff == '0) begin
                     numeric_in = (in_byte == CH_HASH);
                  end else if (numeric_ff) begin
                     if (body_len_ff == BL_W'(1) && in_byte == CH_X) begin
                        hex_in = 1'b1;
                     end else if (!digit_ok) begin
                        bad_in = 1'b1;
                     end else begin
                        digit_in = 1'b1;
                        if (!ovf_ff) begin
                           if (acc_over) begin
                              ovf_in = 1'b1;
                           end else begin
                              code_in = acc[CODE_W-1:0];
                           end
                        end
                     end
                  end
                  body_len_in = body_len_ff + BL_W'(1);
               end
            end
            default: begin
               if (in_byte == CH_AMP) begin
                  body_len_in = '0;
                  cand_in     = '1;
                  numeric_in  = 1'b0;
                  hex_in      = 1'b0;
                  digit_in    = 1'b0;
                  bad_in      = 1'b0;
                  code_in     = '0;
                  ovf_in      = 1'b0;
                  mode_in     = MODE_ENTITY;
                  if (in_last) begin
                     err = 1'b1;
                  end
               end else begin
                  cmd_push = 1'b1;
               end
            end
         endcase
         // Malformed entity: one error result, then drop to end of string
         if (err) begin
            cmd_push    = 1'b1;
            cmd_data.op = OP_ERROR;
            mode_in     = in_last ? MODE_PLAIN : MODE_DISCARD;
         end else if (in_last) begin
            mode_in = MODE_PLAIN;
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_PLAIN;
         body_len_ff <= '0;
         cand_ff     <= '0;
         numeric_ff  <= 1'b0;
         hex_ff      <= 1'b0;
         digit_ff    <= 1'b0;
         bad_ff      <= 1'b0;
         code_ff     <= '0;
         ovf_ff      <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         body_len_ff <= body_len_in;
         cand_ff     <= cand_in;
         numeric_ff  <= numeric_in;
         hex_ff      <= hex_in;
         digit_ff    <= digit_in;
         bad_ff      <= bad_in;
         code_ff     <= code_in;
         ovf_ff      <= ovf_in;
      end
   end

endmodule

// ----- rtl/core/xeu_queue.sv -----
// Short command queue between parser and expander
module xeu_queue import xeu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    head_valid,
   output logic    full
);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QC_W-1:0]  count_ff, count_in;

   assign head       = entries_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QC_W'(QUEUE_DEPTH));

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QP_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QP_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QC_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/core/xeu_back.sv -----
// Expander: turns queued commands into result bytes, UTF-8 encoding code points
module xeu_back import xeu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       head_valid,
   output logic       head_pop,
   input  logic       pop,
   output logic       empty,
   output logic [7:0] out_byte,
   output logic [1:0] result_kind,
   output logic       run_last,
   output logic       string_end
);

   logic       valid_ff;
   logic [7:0] byte_ff, byte_in;
   logic [1:0] kind_ff, kind_in;
   logic       run_last_ff, run_last_in;
   logic       str_end_ff, str_end_in;
   logic [1:0] idx_ff, idx_in;

   logic       slot_free;
   logic       load;
   logic [1:0] nb_m1;
   logic [1:0] shift_sel;

   assign slot_free = !valid_ff || pop;
   assign load      = slot_free && head_valid;
   assign head_pop  = load && run_last_in;

   // Result count of the head command, less one
   always_comb begin
      nb_m1 = 2'd0;
      if (head.op == OP_CODE) begin
         if (head.code < 21'h80) begin
            nb_m1 = 2'd0;
         end else if (head.code < 21'h800) begin
            nb_m1 = 2'd1;
         end else if (head.code < 21'h10000) begin
            nb_m1 = 2'd2;
         end else begin
            nb_m1 = 2'd3;
         end
      end
   end

   // Byte at the current position of the head command
   always_comb begin
      shift_sel = nb_m1 - idx_ff;
      byte_in   = 8'h00;
      kind_in   = KIND_DATA;
      case (head.op)
         OP_RAW: begin
            byte_in = head.code[7:0];
         end
         OP_CODE: begin
            if (idx_ff == 2'd0) begin
               case (nb_m1)
                  2'd0:    byte_in = {1'b0, head.code[6:0]};
                  2'd1:    byte_in = UTF8_LEAD2 | {3'b000, head.code[10:6]};
                  2'd2:    byte_in = UTF8_LEAD3 | {4'b0000, head.code[15:12]};
                  default: byte_in = UTF8_LEAD4 | {5'b00000, head.code[20:18]};
               endcase
            end else begin
               case (shift_sel)
                  2'd0:    byte_in = UTF8_CONT | {2'b00, head.code[5:0]};
                  2'd1:    byte_in = UTF8_CONT | {2'b00, head.code[11:6]};
                  default: byte_in = UTF8_CONT | {2'b00, head.code[17:12]};
               endcase
            end
         end
         OP_ERROR: begin
            kind_in = KIND_ERROR;
         end
         default: begin
            kind_in = KIND_END;
         end
      endcase
      run_last_in = (idx_ff == nb_m1);
      str_end_in  = run_last_in && head.last;
      idx_in      = idx_ff;
      if (load) begin
         idx_in = run_last_in ? 2'd0 : idx_ff + 2'd1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         idx_ff <= idx_in;
         if (slot_free) begin
            valid_ff <= head_valid;
         end
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff     <= byte_in;
         kind_ff     <= kind_in;
         run_last_ff <= run_last_in;
         str_end_ff  <= str_end_in;
      end
   end

   assign empty       = !valid_ff;
   assign out_byte    = byte_ff;
   assign result_kind = kind_ff;
   assign run_last    = run_last_ff;
   assign string_end  = str_end_ff;

endmodule

// ----- rtl/core/xml_entity_unescape_to_utf8.sv -----
// Top level of the XML entity unescaper with UTF-8 output.
// Path: a request's first result passes the command queue entry and then the output register.
// Throughput: one request per cycle while full is low; the expander gives one result per cycle while
// its output is popped, so a multi-byte UTF-8 reference holds it per byte and the 4-deep queue absorbs it.
// Reset: synchronous, active high; clears parser state, queue and output valid flag.
`include "assert_macros.svh"
module xml_entity_unescape_to_utf8 import xeu_pkg::*; #(
   parameter int unsigned MAX_ENTITY_SPAN = SPAN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   output logic       full,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       empty,
   input  logic       pop,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_result_kind,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);

   logic    accept;
   logic    cmd_push;
   cmd_type cmd_data;
   cmd_type head;
   logic    head_valid;
   logic    head_pop;

   assign accept = push && !full;

   // Front: parse and classify
   xeu_front #(
      .MAX_ENTITY_SPAN (MAX_ENTITY_SPAN)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .in_last  (req_in_last),
      .cmd_push (cmd_push),
      .cmd_data (cmd_data)
   );

   // Decoupling queue
   xeu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_data),
      .pop        (head_pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (full)
   );

   // Back: expand into result bytes
   xeu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .head_valid  (head_valid),
      .head_pop    (head_pop),
      .pop         (pop),
      .empty       (empty),
      .out_byte    (rsp_out_byte),
      .result_kind (rsp_result_kind),
      .run_last    (rsp_run_last),
      .string_end  (rsp_string_end)
   );

   // Checks
   `ASSERT_IMPL(a_nondata_zero, clock, reset, !empty && rsp_result_kind != KIND_DATA, rsp_out_byte == 8'h00)
   `ASSERT_IMPL(a_end_closes, clock, reset, !empty && rsp_string_end, rsp_run_last)
   `ASSERT_IMPL(a_end_kind, clock, reset, !empty && rsp_result_kind == KIND_END, rsp_string_end)
   `ASSERT_NEXT(a_run_no_gap, clock, reset, !empty && pop && !rsp_run_last, !empty)

endmodule
